### hw/rtl/chm_pkg.sv
// Shared types and constants for the monotone chain convex hull block.
package chm_pkg;

    localparam int QDEPTH = 4;

    typedef struct packed {
        logic valid;
        logic last;
    } t_q_head;

endpackage

### hw/rtl/chm_front.sv
// Front end: input handshake and request queue feeding the hull engine.
module chm_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [COORD_BITS-1:0]   i_point_x,
    input  logic [COORD_BITS-1:0]   i_point_y,
    input  logic                    i_set_end,
    output chm_pkg::t_q_head        o_head,
    output logic [2*COORD_BITS-1:0] o_head_pt,
    input  logic                    i_pop
);
    import chm_pkg::*;

    localparam int QW = $clog2(QDEPTH);
    localparam int EW = 2 * COORD_BITS + 1;

    logic [EW-1:0] r_q [QDEPTH];
    logic [QW-1:0] r_wp, r_rp;
    logic [QW:0]   r_cnt;
    logic          push, pop;

    assign o_stall = (r_cnt == (QW+1)'(QDEPTH));
    assign push    = i_valid && !o_stall;
    assign pop     = i_pop && (r_cnt != '0);

    assign o_head.valid = (r_cnt != '0);
    assign o_head.last  = r_q[r_rp][0];
    assign o_head_pt    = r_q[r_rp][EW-1:1];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= {i_point_x, i_point_y, i_set_end};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            if (push && !pop)      r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

### hw/rtl/chm_back.sv
// Back end: sorted insertion, lower and upper chain passes, hull emission.
module chm_back #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  chm_pkg::t_q_head        i_head,
    input  logic [2*COORD_BITS-1:0] i_head_pt,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [COORD_BITS-1:0]   o_vertex_x,
    output logic [COORD_BITS-1:0]   o_vertex_y,
    output logic                    o_run_end,
    output logic                    o_overflowed
);
    import chm_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int PTW = 2 * CB;
    localparam int IW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int CAP = MAX_POINTS + 1;
    localparam int SW  = $clog2(CAP);
    localparam int DW  = $clog2(CAP + 1);
    localparam int PW  = 2 * CB + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_CMP, S_H_RD, S_H_LD, S_H_MUL, S_H_DEC, S_H_POP,
        S_E_RD, S_E_LD
    } t_state;

    t_state r_state;

    logic [PTW-1:0] r_pts_mem [MAX_POINTS];
    logic [PTW-1:0] r_stk_mem [CAP];
    logic [PTW-1:0] r_pts_rd, r_stk_rd;

    logic [CW-1:0]  r_count, r_pos, r_k, r_emit_n;
    logic [IW-1:0]  r_i;
    logic [DW-1:0]  r_depth, r_floor;
    logic           r_upper, r_drop, r_last;
    logic [PTW-1:0] r_p, r_a, r_b, r_c;
    logic signed [PW-1:0] r_t1, r_t2;

    logic           out_free;
    logic [IW-1:0]  pts_raddr, pts_waddr;
    logic [PTW-1:0] pts_wdata;
    logic           pts_we;
    logic [SW-1:0]  stk_raddr;
    logic           stk_we;
    logic           pop_ok, turn, take, p_less, stk_full;
    logic [DW-1:0]  new_d, fin_d;
    logic [CW-1:0]  fin_n;
    logic signed [CB:0] dx1, dy1, dx2, dy2;
    logic signed [PW-1:0] prod1, prod2;

    function automatic logic pt_less(input logic [PTW-1:0] a, input logic [PTW-1:0] b);
        logic signed [CB-1:0] ax, ay, bx, by;
        ax = a[PTW-1:CB];
        ay = a[CB-1:0];
        bx = b[PTW-1:CB];
        by = b[CB-1:0];
        return (ax < bx) || ((ax == bx) && (ay < by));
    endfunction

    assign out_free = !o_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && i_head.valid;
    assign p_less   = pt_less(r_p, r_pts_rd);

    assign pop_ok   = (r_depth >= DW'(2)) && (r_depth > r_floor);
    assign turn     = r_t1 < r_t2;
    assign take     = ((r_state == S_H_MUL) && !pop_ok) || ((r_state == S_H_DEC) && !turn);
    assign stk_full = (r_depth == DW'(CAP));
    assign new_d    = stk_full ? r_depth : r_depth + 1'b1;
    assign fin_d    = r_upper ? ((new_d != '0) ? new_d - 1'b1 : new_d) : new_d;
    assign fin_n    = (fin_d < DW'(MAX_POINTS)) ? CW'(fin_d) : CW'(MAX_POINTS);
    assign stk_we   = take && !stk_full;

    assign dx1 = $signed({r_b[PTW-1], r_b[PTW-1:CB]}) - $signed({r_a[PTW-1], r_a[PTW-1:CB]});
    assign dy1 = $signed({r_b[CB-1], r_b[CB-1:0]}) - $signed({r_a[CB-1], r_a[CB-1:0]});
    assign dx2 = $signed({r_c[PTW-1], r_c[PTW-1:CB]}) - $signed({r_b[PTW-1], r_b[PTW-1:CB]});
    assign dy2 = $signed({r_c[CB-1], r_c[CB-1:0]}) - $signed({r_b[CB-1], r_b[CB-1:0]});

    assign prod1 = PW'(dx1) * PW'(dy2);
    assign prod2 = PW'(dy1) * PW'(dx2);

    always_comb begin
        pts_raddr = r_i;
        pts_we    = 1'b0;
        pts_waddr = IW'(r_pos);
        pts_wdata = r_p;
        stk_raddr = SW'(r_k);
        if (r_state == S_INS_RD) begin
            pts_raddr = IW'(r_pos - 1'b1);
            if (r_pos == '0) pts_we = 1'b1;
        end
        if (r_state == S_INS_CMP) begin
            pts_we = 1'b1;
            if (p_less) pts_wdata = r_pts_rd;
        end
        if (r_state == S_H_DEC) stk_raddr = SW'(r_depth - DW'(3));
    end

    always_ff @(posedge i_clk) begin
        if (pts_we) r_pts_mem[pts_waddr] <= pts_wdata;
        r_pts_rd <= r_pts_mem[pts_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) r_stk_mem[SW'(r_depth)] <= r_c;
        r_stk_rd <= r_stk_mem[stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_depth      <= '0;
            r_floor      <= '0;
            r_upper      <= 1'b0;
            r_drop       <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            if (r_state == S_E_LD && out_free) o_valid <= 1'b1;
            else if (!i_stall)                 o_valid <= 1'b0;
            if (take) begin
                if (!stk_full) begin
                    r_a <= r_b;
                    r_b <= r_c;
                end
                if (!r_upper) begin
                    r_depth <= new_d;
                    if (CW'(r_i) == r_count - 1'b1) begin
                        if (CW'(new_d) == r_count && new_d <= DW'(MAX_POINTS)) begin
                            r_k      <= '0;
                            r_emit_n <= fin_n;
                            r_state  <= S_E_RD;
                        end else begin
                            r_floor <= new_d;
                            r_upper <= 1'b1;
                            r_i     <= r_i - 1'b1;
                            r_state <= S_H_RD;
                        end
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_H_RD;
                    end
                end else begin
                    if (r_i == '0) begin
                        r_upper  <= 1'b0;
                        r_depth  <= fin_d;
                        r_k      <= '0;
                        r_emit_n <= fin_n;
                        r_state  <= S_E_RD;
                    end else begin
                        r_depth <= new_d;
                        r_i     <= r_i - 1'b1;
                        r_state <= S_H_RD;
                    end
                end
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (i_head.valid) begin
                            if (r_count < CW'(MAX_POINTS)) begin
                                r_p     <= i_head_pt;
                                r_pos   <= r_count;
                                r_last  <= i_head.last;
                                r_state <= S_INS_RD;
                            end else begin
                                r_drop <= 1'b1;
                                if (i_head.last) begin
                                    r_depth <= '0;
                                    r_floor <= '0;
                                    r_upper <= 1'b0;
                                    r_i     <= '0;
                                    r_state <= S_H_RD;
                                end
                            end
                        end
                    end
                    S_INS_RD, S_INS_CMP: begin
                        if (r_state == S_INS_CMP && p_less) begin
                            r_pos   <= r_pos - 1'b1;
                            r_state <= S_INS_RD;
                        end else if (r_state == S_INS_RD && r_pos != '0) begin
                            r_state <= S_INS_CMP;
                        end else begin
                            r_count <= r_count + 1'b1;
                            if (r_last) begin
                                r_depth <= '0;
                                r_floor <= '0;
                                r_upper <= 1'b0;
                                r_i     <= '0;
                                r_state <= S_H_RD;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                    S_H_RD: r_state <= S_H_LD;
                    S_H_LD: begin
                        r_c     <= r_pts_rd;
                        r_state <= S_H_MUL;
                    end
                    S_H_MUL: begin
                        r_t1    <= prod1;
                        r_t2    <= prod2;
                        r_state <= S_H_DEC;
                    end
                    S_H_DEC: begin
                        if (turn) begin
                            r_depth <= r_depth - 1'b1;
                            r_b     <= r_a;
                            r_state <= (r_depth >= DW'(3)) ? S_H_POP : S_H_MUL;
                        end
                    end
                    S_H_POP: begin
                        r_a     <= r_stk_rd;
                        r_state <= S_H_MUL;
                    end
                    S_E_RD: r_state <= S_E_LD;
                    S_E_LD: begin
                        if (out_free) begin
                            o_vertex_x   <= r_stk_rd[PTW-1:CB];
                            o_vertex_y   <= r_stk_rd[CB-1:0];
                            o_run_end    <= (r_k + 1'b1 == r_emit_n);
                            o_overflowed <= r_drop;
                            if (r_k + 1'b1 == r_emit_n) begin
                                r_count <= '0;
                                r_depth <= '0;
                                r_drop  <= 1'b0;
                                r_state <= S_IDLE;
                            end else begin
                                r_k     <= r_k + 1'b1;
                                r_state <= S_E_RD;
                            end
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    a_depth_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(CAP)) else $error("hull stack depth beyond capacity");
    a_upper_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upper |-> r_depth >= r_floor) else $error("upper pass popped into lower chain");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS)) else $error("point count beyond capacity");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == S_IDLE) else $error("request taken while busy");

endmodule

### hw/rtl/convex_hull_monotone_chain.sv
// Steps: each dequeued point is sorted into place by insertion, shifting larger points up
// one slot at a time. On the last point of a set, the lower and then the upper chain pass
// runs, each step loading a point, testing the turn and popping the stack on a clockwise
// turn; the hull vertices are then emitted one at a time.
// Throughput: one set at a time; a 4-entry request queue absorbs input while busy.
// Reset (synchronous, active low) clears the queue, point count, stack depth and drop flag.
module convex_hull_monotone_chain #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [COORD_BITS-1:0] i_point_x,
    input  logic [COORD_BITS-1:0] i_point_y,
    input  logic                  i_set_end,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COORD_BITS-1:0] o_vertex_x,
    output logic [COORD_BITS-1:0] o_vertex_y,
    output logic                  o_run_end,
    output logic                  o_overflowed
);
    import chm_pkg::*;

    t_q_head                 head;
    logic [2*COORD_BITS-1:0] head_pt;
    logic                    pop;

    chm_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_set_end (i_set_end),
        .o_head    (head),
        .o_head_pt (head_pt),
        .i_pop     (pop)
    );

    chm_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_pt    (head_pt),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_vertex_x   (o_vertex_x),
        .o_vertex_y   (o_vertex_y),
        .o_run_end    (o_run_end),
        .o_overflowed (o_overflowed)
    );

endmodule

### verif/tb_convex_hull_monotone_chain.sv
// Testbench for convex_hull_monotone_chain: point sets checked against a hull predictor.
module tb_convex_hull_monotone_chain;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS = 64;
    localparam int CB = 16;
    localparam int WD_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic                 run_end;
        logic                 ovf;
    } t_vertex;

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
    } t_pt;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    logic [CB-1:0] i_point_x = '0;
    logic [CB-1:0] i_point_y = '0;
    logic i_set_end = 0;
    logic o_valid;
    logic i_stall = 1;
    logic [CB-1:0] o_vertex_x;
    logic [CB-1:0] o_vertex_y;
    logic o_run_end;
    logic o_overflowed;

    convex_hull_monotone_chain #(.MAX_POINTS(NPTS), .COORD_BITS(CB)) DUT (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    t_pt pts[$];
    bit dropped;
    t_vertex hull_q[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit hold_req = 0;
    bit rx_random = 1;

    function automatic bit cw(t_pt a, t_pt b, t_pt c);
        longint t1, t2;
        t1 = (longint'(b.x) - a.x) * (longint'(c.y) - b.y);
        t2 = (longint'(b.y) - a.y) * (longint'(c.x) - b.x);
        return (t1 - t2) < 0;
    endfunction

    function automatic void chain_add(ref int stk[NPTS+1], ref int sd, input t_pt s[$],
                                      input int idx, input int fl);
        while (sd >= 2 && sd > fl && cw(s[stk[sd-2]], s[stk[sd-1]], s[idx]))
            sd--;
        if (sd < NPTS + 1) begin
            stk[sd] = idx;
            sd++;
        end
    endfunction

    // accepts one point and, at set end, queues the expected hull
    function automatic void predict_hull(t_pt p, bit last);
        t_pt s[$];
        int stk[NPTS+1];
        int n, lower, emit, pos, sd;
        t_vertex v;
        if (pts.size() < NPTS) begin
            pos = pts.size();
            while (pos > 0 && (p.x < pts[pos-1].x ||
                   (p.x == pts[pos-1].x && p.y < pts[pos-1].y)))
                pos--;
            pts.insert(pos, p);
        end else begin
            dropped = 1;
        end
        if (!last) return;
        s = pts;
        n = s.size();
        sd = 0;
        for (int i = 0; i < n; i++) chain_add(stk, sd, s, i, 0);
        if (sd != n) begin
            lower = sd;
            for (int i = n - 1; i > 0; i--) chain_add(stk, sd, s, i - 1, lower);
            if (sd > 0) sd--;
        end
        emit = sd < NPTS ? sd : NPTS;
        for (int i = 0; i < emit; i++) begin
            v.x = s[stk[i]].x;
            v.y = s[stk[i]].y;
            v.run_end = (i + 1 == emit);
            v.ovf = dropped;
            hull_q = {hull_q, v};
        end
        pts.delete();
        dropped = 0;
    endfunction

    // valid stays high after an accept so a following request can go out back to back
    task automatic send_point(int x, int y, bit last, int gap = -1);
        int g;
        g = gap < 0 ? $urandom_range(0, 11) : gap;
        if ($urandom_range(0, 3) == 0) g = 0;
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1;
        i_point_x <= x[CB-1:0];
        i_point_y <= y[CB-1:0];
        i_set_end <= last;
        do @(posedge i_clk); while (o_stall);
        predict_hull('{x[CB-1:0], y[CB-1:0]}, last);
    endtask

    task automatic stop_sending();
        i_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (hull_q.size() != 0) @(posedge i_clk);
    endtask

    // receiver stall pattern
    initial begin
        int w;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_stall <= 1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 0;
            end else begin
                w = rx_random ? $urandom_range(0, 11) : 0;
                if ($urandom_range(0, 2) == 0) w = 0;
                if (w > 0) begin
                    i_stall <= 1;
                    repeat (w) @(posedge i_clk);
                end
                i_stall <= 0;
                do @(posedge i_clk); while (!(o_valid && !i_stall) && !hold_req);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_vertex e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (hull_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex x=%0d y=%0d", $signed(o_vertex_x),
                             $signed(o_vertex_y));
            end else begin
                e = hull_q.pop_front();
                if (e.x !== o_vertex_x || e.y !== o_vertex_y ||
                    e.run_end !== o_run_end || e.ovf !== o_overflowed) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("vertex mismatch exp %0d,%0d,%0b,%0b got %0d,%0d,%0b,%0b",
                                 e.x, e.y, e.run_end, e.ovf, $signed(o_vertex_x),
                                 $signed(o_vertex_y), o_run_end, o_overflowed);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("convex_hull_monotone_chain test failed");
            $finish;
        end
    end

    task automatic test_small_sets();
        send_point(5, 5, 1);
        send_point(-32768, 32767, 0);
        send_point(32767, -32768, 1);
        send_point(0, 0, 0);
        send_point(0, 0, 0);
        send_point(0, 0, 1);
    endtask

    task automatic test_shapes();
        // square with a collinear edge point and an interior point
        send_point(0, 0, 0);
        send_point(10, 10, 0);
        send_point(10, 0, 0);
        send_point(5, 0, 0);
        send_point(3, 4, 0);
        send_point(0, 10, 1);
        // extremes of the coordinate range
        send_point(32767, 32767, 0);
        send_point(-32768, -32768, 0);
        send_point(32767, -32768, 0);
        send_point(-32768, 32767, 0);
        send_point(-1, 21845, 0);
        send_point(-21846, 0, 1);
        // all on a line
        send_point(3, 3, 0);
        send_point(1, 1, 0);
        send_point(2, 2, 1);
        stop_sending();
    endtask

    task automatic test_overflow();
        for (int i = 0; i < NPTS + 3; i++)
            send_point($urandom_range(0, 65535), $urandom_range(0, 65535),
                       i == NPTS + 2, 0);
        stop_sending();
        drain();
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        for (int s = 0; s < 3; s++)
            for (int i = 0; i < 5; i++)
                send_point($urandom_range(0, 65535), $urandom_range(0, 65535),
                           i == 4, 0);
        stop_sending();
        drain();
    endtask

    task automatic test_random();
        int n, span, k;
        k = 0;
        while (k < 50) begin
            n = $urandom_range(0, 5) == 0 ? $urandom_range(1, 3) : $urandom_range(3, 12);
            span = $urandom_range(0, 2) == 0 ? 8 : 65535;
            rx_random = $urandom_range(0, 3) != 0;
            for (int i = 0; i < n; i++) begin
                if (span == 8)
                    send_point($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4, i == n - 1);
                else
                    send_point($urandom_range(0, span), $urandom_range(0, span), i == n - 1);
            end
            k += n;
            if ($urandom_range(0, 7) == 0) begin
                stop_sending();
                drain();
            end
        end
        stop_sending();
        rx_random = 1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_small_sets();
        test_shapes();
        drain();
        test_overflow();
        test_backpressure();
        test_random();
        drain();
        repeat (400) @(posedge i_clk);
        if (mismatches == 0 && hull_q.size() == 0)
            $display("convex_hull_monotone_chain test passed");
        else
            $display("convex_hull_monotone_chain test failed");
        $finish;
    end
endmodule
